// File: hw/rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants of the priority event scheduler
// Operation codes, field widths, the not-started priority value and the queue length reset value.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int PRIO_W = 8;
  localparam int SIG_W  = 8;
  localparam int PAR_W  = 16;
  localparam int OP_W   = 3;
  localparam int LEN_W  = 4;
  localparam int EVT_W  = SIG_W + PAR_W;

  localparam logic [OP_W-1:0] OP_POST   = 3'd0;
  localparam logic [OP_W-1:0] OP_DONE   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_START  = 3'd4;

  localparam logic [PRIO_W-1:0] PRIO_NOT_STARTED = 8'hFF;
  localparam logic [31:0]       QLEN_RESET       = 32'h8888_8888;

  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [EVT_W-1:0]  event_t;

endpackage

// File: hw/rtl/pes_ram.sv
// ----------------------------------------------------------------------------
// pes_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module pes_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/priority_event_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_event_queue_scheduler: preemptive priority scheduler with event queues
// One ring queue per priority, ready mask, preemption stack and mutex ceiling.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command transaction (tuser = op, tdata = prio, sig, par).
//   out_* : results; every command gives one status transaction (tuser = 0),
//           optionally followed by one dispatch transaction (tuser = 1).
//           tlast marks the final result of a command.
//   cfg_* : write of the packed queue length register, always ready; write
//           it only while no command is in flight.
// Timing: a command is registered on accept and executes once no dispatch
// is pending and the result register is free, loading its status there.
// A dispatch follows once the status is taken, its event read from the
// event RAM (or taken from a post to the same slot by the same command).
// Throughput: one command per cycle without dispatch while out_tready is
// high; a dispatch holds the next command until it enters the output register.
// Reset: queues empty, ready mask clear, stack empty, current priority 255
// (not started), queue lengths 0x88888888. Event RAM is not cleared.
// Output stall: the result register holds; a command waits in the input
// register and in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module priority_event_queue_scheduler
  import pes_pkg::*;
#(
  parameter int NUM_PRIO    = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // prio[7:0], sig[15:8], par[31:16]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[0], out_prio[8:1], out_sig[16:9],
                                  // out_par[32:17], zero[39:33]
  output logic [0:0]  out_tuser,  // kind[0]
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [31:0] cfg_tdata   // queue_lengths[31:0]
);

  localparam int IDXW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SPW  = $clog2(NUM_PRIO + 1);
  localparam int MD   = NUM_PRIO * QUEUE_DEPTH;
  localparam int AW   = (MD > 1) ? $clog2(MD) : 1;

  // configuration
  logic [31:0] qlen_r;

  // input register
  logic                 in_vld_r;
  logic [OP_W-1:0]      in_op_r;
  prio_t                in_prio_r;
  logic [SIG_W-1:0]     in_sig_r;
  logic [PAR_W-1:0]     in_par_r;

  // scheduler state
  logic [QW-1:0]        head_r  [NUM_PRIO];
  logic [QW-1:0]        tail_r  [NUM_PRIO];
  logic [CW-1:0]        cnt_r   [NUM_PRIO];
  logic [NUM_PRIO-1:0]  ready_r;
  prio_t                cur_r;
  prio_t                stack_r [NUM_PRIO];
  logic [SPW-1:0]       sp_r;

  // dispatch pending
  logic                 disp_pend_r;
  prio_t                disp_prio_r;
  logic                 byp_r;
  event_t               byp_data_r;

  // result register
  logic                 out_vld_r;
  logic                 out_kind_r;
  logic                 out_status_r;
  prio_t                out_prio_r;
  logic [SIG_W-1:0]     out_sig_r;
  logic [PAR_W-1:0]     out_par_r;
  logic                 out_last_r;

  // combinational
  logic                 out_free;
  logic                 exec_fire;
  logic                 is_post, is_done, is_lock, is_unlock, is_start;
  logic [LEN_W-1:0]     len     [NUM_PRIO];
  logic [NUM_PRIO-1:0]  lane_ok;
  logic [NUM_PRIO-1:0]  post_hit;
  logic [NUM_PRIO-1:0]  first_hit;
  logic [NUM_PRIO-1:0]  mask_post;
  logic [NUM_PRIO-1:0]  cnt_nz;
  logic                 post_ok;
  logic [IDXW-1:0]      pidx;
  logic [QW-1:0]        post_head;
  logic                 hr_any;
  logic [IDXW-1:0]      hr_idx;
  prio_t                hr;
  prio_t                cur_eff;
  prio_t                pin;
  logic                 sched_req, can_sched, done_disp;
  logic                 disp, push, pop;
  prio_t                cur_nxt;
  logic [QW-1:0]        deq_tail;
  logic [CW-1:0]        cnt_mid [NUM_PRIO];
  logic [QW-1:0]        head_nxt [NUM_PRIO];
  logic [QW-1:0]        tail_nxt [NUM_PRIO];
  logic [CW-1:0]        cnt_nxt  [NUM_PRIO];
  logic [NUM_PRIO-1:0]  ready_nxt;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  event_t               ram_wdata, ram_rdata;

  assign cfg_tready = 1'b1;
  assign out_free   = !out_vld_r || out_tready;
  assign exec_fire  = in_vld_r && !disp_pend_r && out_free;
  assign in_tready  = !in_vld_r || exec_fire;

  assign is_post   = (in_op_r == OP_POST);
  assign is_done   = (in_op_r == OP_DONE);
  assign is_lock   = (in_op_r == OP_LOCK);
  assign is_unlock = (in_op_r == OP_UNLOCK);
  assign is_start  = (in_op_r == OP_START);

  // per-priority lengths, post acceptance and post lane selection
  always_comb begin
    pidx      = '0;
    post_head = '0;
    for (int i = 0; i < NUM_PRIO; i++) begin
      if (i < 8 && LEN_W'(qlen_r >> (4 * i)) > LEN_W'(QUEUE_DEPTH)) begin
        len[i] = LEN_W'(QUEUE_DEPTH);
      end else if (i < 8) begin
        len[i] = LEN_W'(qlen_r >> (4 * i));
      end else begin
        len[i] = '0;
      end
      lane_ok[i]  = (len[i] != '0) && (LEN_W'(cnt_r[i]) < len[i]);
      post_hit[i] = is_post && (in_prio_r == PRIO_W'(i + 1));
      cnt_nz[i]   = (cnt_r[i] != '0);
      if (post_hit[i]) begin
        pidx      = IDXW'(i);
        post_head = head_r[i];
      end
    end
    post_ok   = |(post_hit & lane_ok);
    first_hit = post_hit & lane_ok & ~cnt_nz;
    mask_post = ready_r | first_hit;
  end

  // highest ready priority
  always_comb begin
    hr_any = 1'b0;
    hr_idx = '0;
    for (int i = 0; i < NUM_PRIO; i++) begin
      if (mask_post[i]) begin
        hr_any = 1'b1;
        hr_idx = IDXW'(i);
      end
    end
    hr = hr_any ? PRIO_W'(hr_idx) + PRIO_W'(1) : '0;
  end

  // scheduling decision
  always_comb begin
    if (is_unlock && in_prio_r < cur_r) begin
      cur_eff = in_prio_r;
    end else if (is_start) begin
      cur_eff = '0;
    end else begin
      cur_eff = cur_r;
    end
    pin       = stack_r[IDXW'(sp_r - SPW'(1))];
    sched_req = (is_post && |first_hit) || (is_unlock && in_prio_r < cur_r) || is_start;
    can_sched = hr_any && (hr > cur_eff) && (sp_r < SPW'(NUM_PRIO));
    done_disp = hr_any && (hr > pin);
    push      = sched_req && can_sched;
    disp      = push || (is_done && sp_r != '0 && done_disp);
    pop       = is_done && sp_r != '0 && !done_disp;
    priority if (disp) begin
      cur_nxt = hr;
    end else if (pop) begin
      cur_nxt = pin;
    end else if (is_lock && in_prio_r > cur_r) begin
      cur_nxt = in_prio_r;
    end else begin
      cur_nxt = cur_eff;
    end
  end

  // queue lane updates: post first, then dequeue
  always_comb begin
    deq_tail = '0;
    for (int i = 0; i < NUM_PRIO; i++) begin
      head_nxt[i] = head_r[i];
      cnt_mid[i]  = cnt_r[i];
      if (post_hit[i] && lane_ok[i]) begin
        head_nxt[i] = (LEN_W'(head_r[i]) + LEN_W'(1) >= len[i]) ? '0 : head_r[i] + QW'(1);
        cnt_mid[i]  = cnt_r[i] + CW'(1);
      end
      tail_nxt[i]  = tail_r[i];
      cnt_nxt[i]   = cnt_mid[i];
      ready_nxt[i] = mask_post[i];
      if (disp && hr_idx == IDXW'(i)) begin
        deq_tail    = tail_r[i];
        tail_nxt[i] = (LEN_W'(tail_r[i]) + LEN_W'(1) >= len[i]) ? '0 : tail_r[i] + QW'(1);
        if (cnt_mid[i] != '0) begin
          cnt_nxt[i] = cnt_mid[i] - CW'(1);
        end
        if (cnt_nxt[i] == '0) begin
          ready_nxt[i] = 1'b0;
        end
      end
    end
  end

  assign ram_we    = exec_fire && post_ok;
  assign ram_waddr = AW'(pidx) * AW'(QUEUE_DEPTH) + AW'(post_head);
  assign ram_wdata = {in_sig_r, in_par_r};
  assign ram_re    = exec_fire && disp;
  assign ram_raddr = AW'(hr_idx) * AW'(QUEUE_DEPTH) + AW'(deq_tail);

  pes_ram #(
    .WIDTH (EVT_W),
    .DEPTH (MD)
  ) u_evt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= QLEN_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      qlen_r <= cfg_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_prio_r <= in_tdata[7:0];
      in_sig_r  <= in_tdata[15:8];
      in_par_r  <= in_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      ready_r <= '0;
      cur_r   <= PRIO_NOT_STARTED;
      sp_r    <= '0;
    end else if (exec_fire) begin
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
      ready_r <= ready_nxt;
      cur_r   <= cur_nxt;
      if (push) begin
        sp_r <= sp_r + SPW'(1);
      end else if (pop) begin
        sp_r <= sp_r - SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && push) begin
      stack_r[IDXW'(sp_r)] <= cur_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_pend_r <= 1'b0;
    end else if (exec_fire) begin
      disp_pend_r <= disp;
    end else if (disp_pend_r && out_free) begin
      disp_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && disp) begin
      disp_prio_r <= hr;
      byp_r       <= ram_we && (ram_waddr == ram_raddr);
      byp_data_r  <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_fire || (disp_pend_r && out_free)) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_kind_r   <= 1'b0;
      out_status_r <= is_post && !post_ok;
      out_prio_r   <= is_lock ? cur_r : '0;
      out_sig_r    <= '0;
      out_par_r    <= '0;
      out_last_r   <= !disp;
    end else if (disp_pend_r && out_free) begin
      out_kind_r   <= 1'b1;
      out_status_r <= 1'b0;
      out_prio_r   <= disp_prio_r;
      out_sig_r    <= byp_r ? byp_data_r[EVT_W-1:PAR_W] : ram_rdata[EVT_W-1:PAR_W];
      out_par_r    <= byp_r ? byp_data_r[PAR_W-1:0] : ram_rdata[PAR_W-1:0];
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_par_r, out_sig_r, out_prio_r, out_status_r};

  // a status that is not last is always followed by a pending dispatch
  a_status_then_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_kind_r && !out_last_r) |-> disp_pend_r)
    else $error("status without last but no dispatch pending");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(NUM_PRIO))
    else $error("preemption stack overflow");

  a_ready_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r == cnt_nz)
    else $error("ready mask out of step with queue counts");

  a_disp_prio_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r) |-> (out_prio_r != '0))
    else $error("dispatch to idle priority");

endmodule
